// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge out of reset.
`define TKML_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tkml assertion failed");

// Same-cycle implication.
`define TKML_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tkml implication failed");

`endif

// ===== hw/rtl/tkml_pkg.sv =====
`timescale 1ns / 1ps

package tkml_pkg;

  // Default sizes of the list and of the payload fields.
  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned OFFSET_BITS_DEF = 14;
  localparam int unsigned SCORE_BITS_DEF  = 16;

  // Width of the capacity register and of the entry count.
  localparam int unsigned CNT_W = 7;

  localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd40;

  // Command codes of an input beat.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Control part of the scan token that walks down the cell row.
  typedef struct packed {
    logic valid;
    logic first;
  } tkml_tok_ctl_t;

endpackage

// ===== hw/rtl/tkml_if.sv =====
`timescale 1ns / 1ps

// Candidate channel: one insert or clear command per beat.
interface tkml_in_if #(
  parameter int unsigned OFFSET_BITS = tkml_pkg::OFFSET_BITS_DEF,
  parameter int unsigned SCORE_BITS  = tkml_pkg::SCORE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [OFFSET_BITS-1:0] offset_x;
  logic signed [OFFSET_BITS-1:0] offset_y;
  logic        [SCORE_BITS-1:0]  score;

  modport source (output valid, cmd, offset_x, offset_y, score, input ready);
  modport sink   (input valid, cmd, offset_x, offset_y, score, output ready);
endinterface

// Result channel: one beat per command.
interface tkml_out_if #(
  parameter int unsigned OFFSET_BITS = tkml_pkg::OFFSET_BITS_DEF,
  parameter int unsigned SCORE_BITS  = tkml_pkg::SCORE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           taken;
  logic signed [OFFSET_BITS-1:0]  best_x;
  logic signed [OFFSET_BITS-1:0]  best_y;
  logic        [SCORE_BITS-1:0]   best_score;
  logic [tkml_pkg::CNT_W-1:0]     entries;

  modport source (output valid, taken, best_x, best_y, best_score, entries, input ready);
  modport sink   (input valid, taken, best_x, best_y, best_score, entries, output ready);
endinterface

// Configuration channel: writes the list capacity.
interface tkml_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tkml_pkg::CNT_W-1:0] list_capacity;

  modport source (output valid, list_capacity, input ready);
  modport sink   (input valid, list_capacity, output ready);
endinterface

// ===== hw/rtl/tkml_cell.sv =====
`timescale 1ns / 1ps

module tkml_cell #(
  parameter int unsigned MAX_ENTRIES = tkml_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned OFFSET_BITS = tkml_pkg::OFFSET_BITS_DEF,
  parameter int unsigned SCORE_BITS  = tkml_pkg::SCORE_BITS_DEF,
  parameter int unsigned CELL_IDX    = 0,
  localparam int unsigned IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Entry write from the controller.
  input  logic                          wr_en_i,
  input  logic signed [OFFSET_BITS-1:0] wr_x_i,
  input  logic signed [OFFSET_BITS-1:0] wr_y_i,
  input  logic        [SCORE_BITS-1:0]  wr_score_i,
  input  logic [tkml_pkg::CNT_W-1:0]    fill_i,
  // Scan token from the left neighbor.
  input  tkml_pkg::tkml_tok_ctl_t       ctl_i,
  input  logic signed [OFFSET_BITS-1:0] best_x_i,
  input  logic signed [OFFSET_BITS-1:0] best_y_i,
  input  logic        [SCORE_BITS-1:0]  best_score_i,
  input  logic        [SCORE_BITS-1:0]  worst_score_i,
  input  logic        [IDX_W-1:0]       worst_idx_i,
  // Scan token to the right neighbor.
  output tkml_pkg::tkml_tok_ctl_t       ctl_o,
  output logic signed [OFFSET_BITS-1:0] best_x_o,
  output logic signed [OFFSET_BITS-1:0] best_y_o,
  output logic        [SCORE_BITS-1:0]  best_score_o,
  output logic        [SCORE_BITS-1:0]  worst_score_o,
  output logic        [IDX_W-1:0]       worst_idx_o
);
  import tkml_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

  logic signed [OFFSET_BITS-1:0] x_q, y_q;
  logic        [SCORE_BITS-1:0]  score_q;

  tkml_tok_ctl_t                 ctl_d, ctl_q;
  logic signed [OFFSET_BITS-1:0] bx_d, bx_q, by_d, by_q;
  logic        [SCORE_BITS-1:0]  bs_d, bs_q, ws_d, ws_q;
  logic        [IDX_W-1:0]       wi_d, wi_q;
  logic                          held;

  assign held = (MY_CNT < fill_i);

  // Stored entry; held entries are only rewritten by the controller.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      x_q     <= wr_x_i;
      y_q     <= wr_y_i;
      score_q <= wr_score_i;
    end
  end

  // Fold this entry into the running best and worst. Strict compares keep
  // the lowest index on ties since the token moves toward higher indices.
  always_comb begin
    ctl_d.valid = ctl_i.valid;
    ctl_d.first = 1'b0;
    bx_d = best_x_i;
    by_d = best_y_i;
    bs_d = best_score_i;
    ws_d = worst_score_i;
    wi_d = worst_idx_i;
    if (ctl_i.first) begin
      bx_d = x_q;
      by_d = y_q;
      bs_d = score_q;
      ws_d = score_q;
      wi_d = MY_IDX;
    end else if (held) begin
      if (score_q > best_score_i) begin
        bx_d = x_q;
        by_d = y_q;
        bs_d = score_q;
      end
      if (score_q < worst_score_i) begin
        ws_d = score_q;
        wi_d = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bx_q <= bx_d;
    by_q <= by_d;
    bs_q <= bs_d;
    ws_q <= ws_d;
    wi_q <= wi_d;
  end

  assign ctl_o         = ctl_q;
  assign best_x_o      = bx_q;
  assign best_y_o      = by_q;
  assign best_score_o  = bs_q;
  assign worst_score_o = ws_q;
  assign worst_idx_o   = wi_q;

endmodule

// ===== hw/rtl/tkml_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tkml_ctrl #(
  parameter int unsigned MAX_ENTRIES = tkml_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned OFFSET_BITS = tkml_pkg::OFFSET_BITS_DEF,
  parameter int unsigned SCORE_BITS  = tkml_pkg::SCORE_BITS_DEF,
  localparam int unsigned IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tkml_in_if.sink                       cand_i,
  tkml_out_if.source                    res_o,
  tkml_cfg_if.sink                      cfg_i,
  // Entry writes to the cell row.
  output logic [MAX_ENTRIES-1:0]        wr_en_o,
  output logic signed [OFFSET_BITS-1:0] wr_x_o,
  output logic signed [OFFSET_BITS-1:0] wr_y_o,
  output logic        [SCORE_BITS-1:0]  wr_score_o,
  output logic [tkml_pkg::CNT_W-1:0]    fill_o,
  // Head and tail of the scan token.
  output tkml_pkg::tkml_tok_ctl_t       head_ctl_o,
  input  tkml_pkg::tkml_tok_ctl_t       tail_ctl_i,
  input  logic signed [OFFSET_BITS-1:0] tail_best_x_i,
  input  logic signed [OFFSET_BITS-1:0] tail_best_y_i,
  input  logic        [SCORE_BITS-1:0]  tail_best_score_i,
  input  logic        [SCORE_BITS-1:0]  tail_worst_score_i,
  input  logic        [IDX_W-1:0]       tail_worst_idx_i
);
  import tkml_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  // Latched command beat.
  logic                          cmd_q;
  logic signed [OFFSET_BITS-1:0] x_q, y_q;
  logic        [SCORE_BITS-1:0]  sc_q;

  logic [CNT_W-1:0] cap_q, cap_eff;
  logic [CNT_W-1:0] fill_q, fill_d;

  // Best entry and worst score/index of the held list.
  logic signed [OFFSET_BITS-1:0] best_x_q, best_x_d, best_y_q, best_y_d;
  logic        [SCORE_BITS-1:0]  best_s_q, best_s_d, worst_s_q, worst_s_d;
  logic        [IDX_W-1:0]       worst_i_q, worst_i_d;

  logic launch_q, launch_d;

  // Result register.
  logic                          out_valid_q;
  logic                          out_ld, out_taken;
  logic                          taken_q;
  logic signed [OFFSET_BITS-1:0] ox_q, oy_q;
  logic        [SCORE_BITS-1:0]  os_q;
  logic [CNT_W-1:0]              oent_q;

  logic in_fire, cfg_fire, out_free, full;

  assign cand_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign in_fire      = cand_i.valid && cand_i.ready;
  assign cfg_fire     = cfg_i.valid && cfg_i.ready;
  assign out_free     = !out_valid_q || res_o.ready;

  // Capacity clamped to 1..MAX_ENTRIES.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_q > MAX_CNT) begin
      cap_eff = MAX_CNT;
    end else begin
      cap_eff = cap_q;
    end
  end

  assign full = (fill_q >= cap_eff);

  // Sequencer: append, clear and reject finish in one step; a replacement
  // writes the worst cell and sends a token down the row for a rescan.
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    best_x_d  = best_x_q;
    best_y_d  = best_y_q;
    best_s_d  = best_s_q;
    worst_s_d = worst_s_q;
    worst_i_d = worst_i_q;
    launch_d  = 1'b0;
    out_ld    = 1'b0;
    out_taken = 1'b0;
    wr_en_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_q == CMD_CLEAR) begin
          if (out_free) begin
            fill_d  = '0;
            out_ld  = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (!full) begin
          if (out_free) begin
            wr_en_o[fill_q[IDX_W-1:0]] = 1'b1;
            fill_d = fill_q + CNT_W'(1);
            if ((fill_q == '0) || (sc_q > best_s_q)) begin
              best_x_d = x_q;
              best_y_d = y_q;
              best_s_d = sc_q;
            end
            if ((fill_q == '0) || (sc_q < worst_s_q)) begin
              worst_s_d = sc_q;
              worst_i_d = fill_q[IDX_W-1:0];
            end
            out_ld    = 1'b1;
            out_taken = 1'b1;
            state_d   = ST_IDLE;
          end
        end else if (sc_q > worst_s_q) begin
          wr_en_o[worst_i_q] = 1'b1;
          launch_d = 1'b1;
          state_d  = ST_SCAN;
        end else if (out_free) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (tail_ctl_i.valid) begin
          best_x_d  = tail_best_x_i;
          best_y_d  = tail_best_y_i;
          best_s_d  = tail_best_score_i;
          worst_s_d = tail_worst_score_i;
          worst_i_d = tail_worst_idx_i;
          state_d   = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_ld    = 1'b1;
          out_taken = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      cap_q       <= CAPACITY_RESET;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      launch_q <= launch_d;
      if (cfg_fire) begin
        cap_q <= cfg_i.list_capacity;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cand_i.cmd;
      x_q   <= cand_i.offset_x;
      y_q   <= cand_i.offset_y;
      sc_q  <= cand_i.score;
    end
    best_x_q  <= best_x_d;
    best_y_q  <= best_y_d;
    best_s_q  <= best_s_d;
    worst_s_q <= worst_s_d;
    worst_i_q <= worst_i_d;
    if (out_ld) begin
      taken_q <= out_taken;
      oent_q  <= fill_d;
      if (fill_d == '0) begin
        ox_q <= '0;
        oy_q <= '0;
        os_q <= '0;
      end else begin
        ox_q <= best_x_d;
        oy_q <= best_y_d;
        os_q <= best_s_d;
      end
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.taken      = taken_q;
  assign res_o.best_x     = ox_q;
  assign res_o.best_y     = oy_q;
  assign res_o.best_score = os_q;
  assign res_o.entries    = oent_q;

  assign wr_x_o     = x_q;
  assign wr_y_o     = y_q;
  assign wr_score_o = sc_q;
  assign fill_o     = fill_q;

  // The token starts in the cycle after the replacement write, so the new entry is already stored.
  assign head_ctl_o.valid = launch_q;
  assign head_ctl_o.first = 1'b1;

  `TKML_ASSERT(a_fill_bound, fill_q <= MAX_CNT)
  `TKML_ASSERT(a_single_write, $onehot0(wr_en_o))
  `TKML_ASSERT_IMP(a_tail_in_scan, tail_ctl_i.valid, state_q == ST_SCAN)
  `TKML_ASSERT_IMP(a_order, fill_q != '0, worst_s_q <= best_s_q)
  `TKML_ASSERT_IMP(a_taken_nonempty, res_o.valid && res_o.taken, res_o.entries != '0)

endmodule

// ===== hw/rtl/top_k_match_list_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                         Handshake
// cand_i    in   cmd, offset_x, offset_y, score                 valid/ready
// res_o     out  taken, best_x, best_y, best_score, entries     valid/ready
// cfg_i     in   list_capacity                                  valid/ready
//
// Clear, append and rejected inserts latch the beat, then update the list
// and load the result register once it is free.
// A replacement writes the worst cell, then waits for the scan token that
// walks the row of MAX_ENTRIES cells, one cell per cycle, before its result.
// Reset clears the count and restores the capacity to 40; the stored
// entries are not cleared. A stalled result holds in its register while the
// next beat is taken; that beat then waits there until the result drains.

module top_k_match_list_top #(
  parameter int unsigned MAX_ENTRIES = tkml_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned OFFSET_BITS = tkml_pkg::OFFSET_BITS_DEF,
  parameter int unsigned SCORE_BITS  = tkml_pkg::SCORE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tkml_in_if.sink    cand_i,
  tkml_out_if.source res_o,
  tkml_cfg_if.sink   cfg_i
);
  import tkml_pkg::*;

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [MAX_ENTRIES-1:0]        wr_en;
  logic signed [OFFSET_BITS-1:0] wr_x, wr_y;
  logic        [SCORE_BITS-1:0]  wr_score;
  logic [CNT_W-1:0]              fill;

  // Token links; link k feeds cell k, the last link returns to control.
  tkml_tok_ctl_t                 tok_ctl [MAX_ENTRIES+1];
  logic signed [OFFSET_BITS-1:0] tok_bx  [MAX_ENTRIES+1];
  logic signed [OFFSET_BITS-1:0] tok_by  [MAX_ENTRIES+1];
  logic        [SCORE_BITS-1:0]  tok_bs  [MAX_ENTRIES+1];
  logic        [SCORE_BITS-1:0]  tok_ws  [MAX_ENTRIES+1];
  logic        [IDX_W-1:0]       tok_wi  [MAX_ENTRIES+1];

  // The head cell loads its own entry, so the head payload is a don't-care.
  assign tok_bx[0] = '0;
  assign tok_by[0] = '0;
  assign tok_bs[0] = '0;
  assign tok_ws[0] = '0;
  assign tok_wi[0] = '0;

  tkml_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .OFFSET_BITS (OFFSET_BITS),
    .SCORE_BITS  (SCORE_BITS)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cand_i             (cand_i),
    .res_o              (res_o),
    .cfg_i              (cfg_i),
    .wr_en_o            (wr_en),
    .wr_x_o             (wr_x),
    .wr_y_o             (wr_y),
    .wr_score_o         (wr_score),
    .fill_o             (fill),
    .head_ctl_o         (tok_ctl[0]),
    .tail_ctl_i         (tok_ctl[MAX_ENTRIES]),
    .tail_best_x_i      (tok_bx[MAX_ENTRIES]),
    .tail_best_y_i      (tok_by[MAX_ENTRIES]),
    .tail_best_score_i  (tok_bs[MAX_ENTRIES]),
    .tail_worst_score_i (tok_ws[MAX_ENTRIES]),
    .tail_worst_idx_i   (tok_wi[MAX_ENTRIES])
  );

  // Row of entry cells.
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    tkml_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .OFFSET_BITS (OFFSET_BITS),
      .SCORE_BITS  (SCORE_BITS),
      .CELL_IDX    (k)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .wr_en_i       (wr_en[k]),
      .wr_x_i        (wr_x),
      .wr_y_i        (wr_y),
      .wr_score_i    (wr_score),
      .fill_i        (fill),
      .ctl_i         (tok_ctl[k]),
      .best_x_i      (tok_bx[k]),
      .best_y_i      (tok_by[k]),
      .best_score_i  (tok_bs[k]),
      .worst_score_i (tok_ws[k]),
      .worst_idx_i   (tok_wi[k]),
      .ctl_o         (tok_ctl[k+1]),
      .best_x_o      (tok_bx[k+1]),
      .best_y_o      (tok_by[k+1]),
      .best_score_o  (tok_bs[k+1]),
      .worst_score_o (tok_ws[k+1]),
      .worst_idx_o   (tok_wi[k+1])
    );
  end

endmodule

// ===== dv/top_k_match_list_top_tb.sv =====
`timescale 1ns / 1ps

module top_k_match_list_top_tb;
  import tkml_pkg::*;

  localparam int unsigned LIST_DEPTH  = MAX_ENTRIES_DEF;
  localparam int unsigned OFF_W       = OFFSET_BITS_DEF;
  localparam int unsigned SC_W        = SCORE_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SEGMENTS    = 20;
  localparam int unsigned SEG_ITEMS   = 70;

  // One candidate beat as the sender sees it.
  typedef struct packed {
    logic                    cmd;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic [SC_W-1:0]         score;
  } cand_t;

  // One result beat: the best match after the command.
  typedef struct packed {
    logic                    taken;
    logic signed [OFF_W-1:0] best_x;
    logic signed [OFF_W-1:0] best_y;
    logic [SC_W-1:0]         best_score;
    logic [CNT_W-1:0]        entries;
  } match_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tkml_in_if  cand ();
  tkml_out_if res ();
  tkml_cfg_if cfg ();

  top_k_match_list_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cand_i (cand),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the match list and its capacity register.
  logic signed [OFF_W-1:0] held_x     [LIST_DEPTH];
  logic signed [OFF_W-1:0] held_y     [LIST_DEPTH];
  logic [SC_W-1:0]         held_score [LIST_DEPTH];
  int unsigned             held_count;
  int unsigned             top_idx;
  int unsigned             low_idx;
  logic [CNT_W-1:0]        capacity_reg;

  match_res_t  best_match_q[$];
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  // Apply one command to the shadow list and return the best match after it.
  function automatic match_res_t apply_candidate(input cand_t c);
    match_res_t  r;
    int unsigned cap;
    int unsigned i;
    r = '0;
    cap = 32'(capacity_reg);
    if (cap < 1) cap = 1;
    if (cap > LIST_DEPTH) cap = LIST_DEPTH;
    if (c.cmd == CMD_CLEAR) begin
      held_count = 0;
      top_idx = 0;
      low_idx = 0;
    end else if (held_count < cap) begin
      held_x[held_count] = c.off_x;
      held_y[held_count] = c.off_y;
      held_score[held_count] = c.score;
      if (held_count == 0) begin
        top_idx = 0;
        low_idx = 0;
      end else begin
        if (c.score > held_score[top_idx]) top_idx = held_count;
        if (c.score < held_score[low_idx]) low_idx = held_count;
      end
      held_count++;
      r.taken = 1'b1;
    end else if (c.score > held_score[low_idx]) begin
      held_x[low_idx] = c.off_x;
      held_y[low_idx] = c.off_y;
      held_score[low_idx] = c.score;
      // Full rescan; strict compares keep the lowest index on ties.
      top_idx = 0;
      low_idx = 0;
      for (i = 1; i < held_count; i++) begin
        if (held_score[i] > held_score[top_idx]) top_idx = i;
        if (held_score[i] < held_score[low_idx]) low_idx = i;
      end
      r.taken = 1'b1;
    end
    if (held_count != 0) begin
      r.best_x = held_x[top_idx];
      r.best_y = held_y[top_idx];
      r.best_score = held_score[top_idx];
    end
    r.entries = held_count[CNT_W-1:0];
    return r;
  endfunction

  // Drive one candidate beat and record its expected result on acceptance.
  task automatic send_candidate(input cand_t c);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      cand.valid <= 1'b0;
      @(negedge clk_i);
    end
    cand.valid    <= 1'b1;
    cand.cmd      <= c.cmd;
    cand.offset_x <= c.off_x;
    cand.offset_y <= c.off_y;
    cand.score    <= c.score;
    do @(posedge clk_i); while (!cand.ready);
    best_match_q.push_back(apply_candidate(c));
  endtask

  task automatic insert_match(input int x, input int y, input int s);
    cand_t c;
    c.cmd = CMD_INSERT;
    c.off_x = x[OFF_W-1:0];
    c.off_y = y[OFF_W-1:0];
    c.score = s[SC_W-1:0];
    send_candidate(c);
  endtask

  task automatic clear_list(input int x, input int y, input int s);
    cand_t c;
    c.cmd = CMD_CLEAR;
    c.off_x = x[OFF_W-1:0];
    c.off_y = y[OFF_W-1:0];
    c.score = s[SC_W-1:0];
    send_candidate(c);
  endtask

  // Hold the sender off until every outstanding result has drained.
  task automatic wait_drained();
    @(negedge clk_i);
    cand.valid <= 1'b0;
    while (best_match_q.size() != 0) @(posedge clk_i);
  endtask

  // Capacity writes happen only with the list idle.
  task automatic write_capacity(input logic [CNT_W-1:0] value);
    wait_drained();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    cfg.valid         <= 1'b1;
    cfg.list_capacity <= value;
    do @(posedge clk_i); while (!cfg.ready);
    capacity_reg = value;
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // Random command: mostly inserts, with scores that favor ties and extremes.
  function automatic cand_t random_candidate();
    cand_t       c;
    logic [31:0] bits_a;
    logic [31:0] bits_b;
    int unsigned mode;
    bits_a = $urandom;
    bits_b = $urandom;
    c.cmd = ($urandom_range(0, 99) < 3) ? CMD_CLEAR : CMD_INSERT;
    c.off_x = bits_a[OFF_W-1:0];
    c.off_y = bits_b[OFF_W-1:0];
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      c.score = bits_a[31:32-SC_W];
    end else if (mode < 8) begin
      c.score = SC_W'($urandom_range(0, 7));
    end else begin
      c.score = bits_b[31] ? '1 : '0;
    end
    return c;
  endfunction

  // Field extremes, ties for best and worst, and clears with junk payload.
  task automatic test_empty_and_extremes();
    clear_list(0, 0, 0);
    insert_match(-8192, 8191, 0);
    insert_match(8191, -8192, 65535);
    insert_match(1, 1, 65535);
    insert_match(2, 2, 0);
    insert_match(-1, -1, 32768);
    clear_list(-1, -1, 65535);
  endtask

  // A one-slot list, and a capacity of zero that behaves the same.
  task automatic test_single_slot();
    write_capacity(7'd1);
    insert_match(100, -100, 100);
    insert_match(5, 5, 50);
    insert_match(6, 6, 100);
    insert_match(7, 7, 101);
    write_capacity(7'd0);
    insert_match(8, 8, 101);
    insert_match(-9, 9, 65535);
  endtask

  // Capacity lowered below the fill count: entries stay, list counts as full.
  task automatic test_shrunk_capacity();
    write_capacity(7'd8);
    clear_list(0, 0, 0);
    insert_match(1, 1, 30);
    insert_match(2, 2, 10);
    insert_match(3, 3, 50);
    insert_match(4, 4, 10);
    insert_match(5, 5, 50);
    write_capacity(7'd2);
    insert_match(6, 6, 5);
    insert_match(7, 7, 20);
    insert_match(8, 8, 10);
    insert_match(9, 9, 60);
  endtask

  // Random traffic in four idling phases, each across several capacities.
  task automatic test_random_traffic();
    logic [CNT_W-1:0] cap_plan [SEGMENTS];
    int unsigned      seg;
    int unsigned      n;
    cap_plan = '{7'd1, 7'd3, 7'd0, 7'd8, 7'd64, 7'd2, 7'd127, 7'd5, 7'd40, 7'd16,
                 7'd65, 7'd1, 7'd12, 7'd64, 7'd4, 7'd6, 7'd2, 7'd20, 7'd0, 7'd64};
    for (seg = 0; seg < SEGMENTS; seg++) begin
      write_capacity(cap_plan[seg]);
      case (seg / 5)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
        default: begin src_idle_pct = 35; sink_stall_pct = 35; end
      endcase
      if ($urandom_range(0, 1) == 0) clear_list(0, 0, 0);
      for (n = 0; n < SEG_ITEMS; n++) begin
        // Now and then the sender waits for the result stream to run dry.
        if ($urandom_range(0, 49) == 0) wait_drained();
        send_candidate(random_candidate());
      end
    end
  endtask

  // Receiver stalls at the configured rate.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Compare every result beat with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    match_res_t got;
    match_res_t want;
    if (rst_ni && res.valid && res.ready) begin
      got = '{res.taken, res.best_x, res.best_y, res.best_score, res.entries};
      result_count++;
      if (best_match_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with nothing expected", result_count);
      end else begin
        want = best_match_q.pop_front();
        if (got.taken !== want.taken || got.best_x !== want.best_x ||
            got.best_y !== want.best_y || got.best_score !== want.best_score ||
            got.entries !== want.entries) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d: expected taken=%0d x=%0d y=%0d score=%0d n=%0d",
                     result_count, want.taken, want.best_x, want.best_y,
                     want.best_score, want.entries);
            $display("result %0d: got      taken=%0d x=%0d y=%0d score=%0d n=%0d",
                     result_count, got.taken, got.best_x, got.best_y,
                     got.best_score, got.entries);
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cand.valid        = 1'b0;
    cand.cmd          = CMD_INSERT;
    cand.offset_x     = '0;
    cand.offset_y     = '0;
    cand.score        = '0;
    cfg.valid         = 1'b0;
    cfg.list_capacity = '0;
    src_idle_pct      = 0;
    sink_stall_pct    = 0;
    mismatch_count    = 0;
    result_count      = 0;
    cycle_count       = 0;
    held_count        = 0;
    top_idx           = 0;
    low_idx           = 0;
    capacity_reg      = CAPACITY_RESET;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_and_extremes();
    test_single_slot();
    test_shrunk_capacity();
    test_random_traffic();

    // Let the last results drain, then watch for strays.
    wait_drained();
    repeat (LIST_DEPTH + 16) @(posedge clk_i);

    if (mismatch_count == 0 && best_match_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
